FILE: src/btc_pkg.sv
// shared types and constants for the balanced ternary converter
`timescale 1ns / 1ps

package btc_pkg;

  localparam int CntW  = 5;
  localparam int ValW  = 32;
  localparam int WordW = 40;

  localparam logic [CntW-1:0] CntReset = 5'd20;

  localparam logic [1:0] CodeZero  = 2'd0;
  localparam logic [1:0] CodePlus  = 2'd1;
  localparam logic [1:0] CodeMinus = 2'd2;

  localparam logic [32:0] Recip3 = 33'h0_AAAA_AAAB;
  localparam int          Recip3Shift = 33;

  localparam logic CmdEncode = 1'b0;
  localparam logic CmdDecode = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic             neg;
    logic [CntW-1:0]  cnt;
    logic [ValW-1:0]  acc;
    logic [WordW-1:0] word;
  } item_t;

endpackage

FILE: src/btc_stage.sv
// one trit step of the conversion pipeline with its stage register
`timescale 1ns / 1ps

module btc_stage #(
  parameter int MAX_TRITS = 20,
  parameter int STAGE     = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  btc_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output btc_pkg::item_t out_item_o
);

  localparam int CW     = btc_pkg::CntW;
  localparam int VW     = btc_pkg::ValW;
  localparam int EncPos = 2 * STAGE;
  localparam int DecPos = 2 * (MAX_TRITS - 1 - STAGE);
  localparam logic [CW-1:0] EncIdx = CW'(STAGE);
  localparam logic [CW-1:0] DecIdx = CW'(MAX_TRITS - 1 - STAGE);

  logic           valid_q;
  btc_pkg::item_t item_q;
  btc_pkg::item_t item_d;
  logic [64:0]    prod;
  logic [VW-1:0]  quot;
  logic [VW-1:0]  rem_full;
  logic [1:0]     rem;
  logic [1:0]     trit_code;
  logic [1:0]     enc_code;
  logic [VW-1:0]  acc3;

  always_comb begin
    item_d    = in_item_i;
    prod      = 65'(in_item_i.acc) * 65'(btc_pkg::Recip3);
    quot      = prod[64:btc_pkg::Recip3Shift];
    rem_full  = in_item_i.acc - (quot << 1) - quot;
    rem       = rem_full[1:0];
    trit_code = in_item_i.word[DecPos +: 2];
    acc3      = (in_item_i.acc << 1) + in_item_i.acc;
    enc_code  = btc_pkg::CodeZero;
    if (in_item_i.cmd == btc_pkg::CmdEncode) begin
      if (EncIdx < in_item_i.cnt) begin
        case (rem)
          2'd0: begin
            enc_code    = btc_pkg::CodeZero;
            item_d.acc  = quot;
          end
          2'd1: begin
            enc_code    = in_item_i.neg ? btc_pkg::CodeMinus : btc_pkg::CodePlus;
            item_d.acc  = quot;
          end
          default: begin
            // digit two: minus (plus for a negative value) with a carry into the next trit
            enc_code    = in_item_i.neg ? btc_pkg::CodePlus : btc_pkg::CodeMinus;
            item_d.acc  = quot + 32'd1;
          end
        endcase
        item_d.word[EncPos +: 2] = enc_code;
      end
    end else begin
      if (DecIdx < in_item_i.cnt) begin
        case (trit_code)
          btc_pkg::CodePlus:  item_d.acc = acc3 + 32'd1;
          btc_pkg::CodeMinus: item_d.acc = acc3 - 32'd1;
          default:            item_d.acc = acc3;
        endcase
      end
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: src/balanced_ternary_converter.sv
// top level: binary to balanced ternary and back, one trit per pipeline stage
//
//   channel  dir  beat contents (lsb first)
//   s_axis   in   tdata: binary_value, trits_in; tuser: command
//   m_axis   out  tdata: trits_out, value_out, overflow, zero pad
//   cfg      in   cfg_data_i: trit_count
//
// one beat per cycle in and out while m_axis_tready is high; each beat passes
// the input register and then one stage per trit position
// reset empties every stage and sets trit_count to 20
// a stage takes a new beat whenever it is empty or its successor moves,
// so bubbles close up while the output stalls
`timescale 1ns / 1ps

module balanced_ternary_converter #(
  parameter int MAX_TRITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // binary_value[31:0], trits_in[71:32]
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // trits_out[39:0], value_out[71:40], overflow[72]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  localparam int CW = btc_pkg::CntW;
  localparam int VW = btc_pkg::ValW;
  localparam int WW = btc_pkg::WordW;

  logic [CW-1:0]  cnt_cfg_q;
  logic [CW-1:0]  cnt_sat;
  logic [VW-1:0]  bin_val;
  logic [VW-1:0]  mag;
  logic           in_valid_q;
  btc_pkg::item_t in_item_q;
  btc_pkg::item_t in_item_d;

  logic           valid [MAX_TRITS+1];
  logic           ready [MAX_TRITS+1];
  btc_pkg::item_t item  [MAX_TRITS+1];
  btc_pkg::item_t last_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_cfg_q <= btc_pkg::CntReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cnt_cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    cnt_sat = (cnt_cfg_q > CW'(MAX_TRITS)) ? CW'(MAX_TRITS) : cnt_cfg_q;
    bin_val = s_axis_tdata[VW-1:0];
    mag     = bin_val[VW-1] ? (~bin_val + 32'd1) : bin_val;
    in_item_d.cmd  = s_axis_tuser;
    in_item_d.neg  = bin_val[VW-1];
    in_item_d.cnt  = cnt_sat;
    in_item_d.acc  = (s_axis_tuser == btc_pkg::CmdEncode) ? mag : '0;
    in_item_d.word = (s_axis_tuser == btc_pkg::CmdDecode) ? s_axis_tdata[VW +: WW] : '0;
  end

  assign s_axis_tready = !in_valid_q || ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= in_item_d;
    end
  end

  assign valid[0] = in_valid_q;
  assign item[0]  = in_item_q;

  for (genvar s = 0; s < MAX_TRITS; s++) begin : g_stage
    btc_stage #(
      .MAX_TRITS(MAX_TRITS),
      .STAGE    (s)
    ) u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (valid[s]),
      .in_ready_o (ready[s]),
      .in_item_i  (item[s]),
      .out_valid_o(valid[s+1]),
      .out_ready_i(ready[s+1]),
      .out_item_o (item[s+1])
    );
  end

  assign ready[MAX_TRITS] = m_axis_tready;
  assign m_axis_tvalid    = valid[MAX_TRITS];
  assign last_item        = item[MAX_TRITS];

  always_comb begin
    m_axis_tdata = '0;
    if (last_item.cmd == btc_pkg::CmdEncode) begin
      m_axis_tdata[WW-1:0] = last_item.word;
      m_axis_tdata[WW+VW]  = (last_item.acc != '0);
    end else begin
      m_axis_tdata[WW +: VW] = last_item.acc;
    end
  end

endmodule

FILE: src/btc_checker.sv
// port-level checks for the balanced ternary converter, bound to the top level
`timescale 1ns / 1ps

module btc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  // a held result keeps its beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // an empty output stage means the whole chain can take a beat
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // encoder never emits the unused trit code
  a_no_code3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tdata[39:0] & (m_axis_tdata[39:0] >> 1) & 40'h55_5555_5555) == 40'h0))
    else $error("trit code 3 on output");

  // a decoded value comes with no trits and no overflow
  a_decode_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[71:40] != 32'h0) |->
      (m_axis_tdata[39:0] == 40'h0) && !m_axis_tdata[72])
    else $error("decode beat mixes encode fields");

endmodule

bind balanced_ternary_converter btc_checker u_btc_checker (.*);

FILE: tb/testbench.sv
// self-checking testbench for the balanced ternary converter
`timescale 1ns / 1ps

module testbench;

  localparam int MaxTrits = 20;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [btc_pkg::WordW-1:0] trits;
    logic [btc_pkg::ValW-1:0]  value;
    logic                      ovf;
  } conv_result_t;

  class ternary_scoreboard;
    logic [btc_pkg::CntW-1:0] trit_count_cfg;
    conv_result_t             awaited[$];
    int                       errors;

    function new();
      trit_count_cfg = btc_pkg::CntReset;
      errors = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function conv_result_t convert_word(logic cmd, logic [btc_pkg::ValW-1:0] v,
                                        logic [btc_pkg::WordW-1:0] t);
      conv_result_t r;
      int unsigned n;
      longint sv;
      longint unsigned mag;
      longint acc;
      logic [1:0] pos_c;
      logic [1:0] neg_c;
      logic [1:0] code;
      n = (trit_count_cfg > MaxTrits) ? MaxTrits : trit_count_cfg;
      r = '0;
      if (cmd == btc_pkg::CmdEncode) begin
        sv = longint'($signed(v));
        mag = (sv < 0) ? longint'(-sv) : longint'(sv);
        pos_c = (sv < 0) ? btc_pkg::CodeMinus : btc_pkg::CodePlus;
        neg_c = (sv < 0) ? btc_pkg::CodePlus : btc_pkg::CodeMinus;
        for (int i = 0; i < int'(n); i++) begin
          case (mag % 3)
            0: begin
              code = btc_pkg::CodeZero;
              mag = mag / 3;
            end
            1: begin
              code = pos_c;
              mag = mag / 3;
            end
            default: begin
              code = neg_c;
              mag = (mag + 1) / 3;
            end
          endcase
          r.trits[2*i +: 2] = code;
        end
        r.ovf = (mag != 0);
      end else begin
        acc = 0;
        for (int i = int'(n) - 1; i >= 0; i--) begin
          code = t[2*i +: 2];
          if (code == btc_pkg::CodePlus) acc = acc * 3 + 1;
          else if (code == btc_pkg::CodeMinus) acc = acc * 3 - 1;
          else acc = acc * 3;
        end
        r.value = acc[btc_pkg::ValW-1:0];
      end
      return r;
    endfunction

    function void note_input(logic cmd, logic [btc_pkg::ValW-1:0] v,
                             logic [btc_pkg::WordW-1:0] t);
      awaited.push_back(convert_word(cmd, v, t));
    endfunction

    function void check_result(logic [79:0] beat);
      conv_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t unexpected result beat %h", $time, beat);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (beat[39:0] !== want.trits) begin
        $display("%0t trits_out expected %h actual %h", $time, want.trits, beat[39:0]);
        errors++;
      end
      if (beat[71:40] !== want.value) begin
        $display("%0t value_out expected %0d actual %0d", $time,
                 $signed(want.value), $signed(beat[71:40]));
        errors++;
      end
      if (beat[72] !== want.ovf) begin
        $display("%0t overflow expected %b actual %b", $time, want.ovf, beat[72]);
        errors++;
      end
      if (beat[79:73] !== 7'd0) begin
        $display("%0t pad expected %h actual %h", $time, 7'd0, beat[79:73]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // binary_value[31:0], trits_in[71:32]
  logic        s_axis_tuser = 1'b0; // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // trits_out[39:0], value_out[71:40], overflow[72]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;

  ternary_scoreboard sb = new();
  bit          calm = 1'b0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;

  balanced_ternary_converter #(
    .MAX_TRITS(MaxTrits)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: check accepted beats and stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left <= gap_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_word(input logic cmd, input logic [btc_pkg::ValW-1:0] v,
                           input logic [btc_pkg::WordW-1:0] t);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 30) ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t, v};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cmd, v, t);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_trit_count(input logic [btc_pkg::CntW-1:0] n);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.trit_count_cfg = n;
  endtask

  function automatic logic [btc_pkg::WordW-1:0] rand_word();
    return {8'($urandom), 32'($urandom)};
  endfunction

  task automatic random_phase(input int items);
    int unsigned n;
    longint unsigned lim;
    longint unsigned off;
    logic [btc_pkg::WordW-1:0] w;
    logic [btc_pkg::ValW-1:0] v;
    n = (sb.trit_count_cfg > MaxTrits) ? MaxTrits : sb.trit_count_cfg;
    lim = 1;
    repeat (n) lim = lim * 3;
    lim = (lim - 1) / 2;
    for (int k = 0; k < items; k++) begin
      if (k == items / 2 && $urandom_range(0, 2) == 0) drain_results();
      w = rand_word();
      case ($urandom_range(0, 9))
        0, 1, 2: send_word(btc_pkg::CmdEncode, $urandom, w);
        3, 4: begin
          off = $urandom_range(0, 32'(2 * lim));
          v = 32'(longint'(off) - longint'(lim));
          send_word(btc_pkg::CmdEncode, v, w);
        end
        5: begin
          case ($urandom_range(0, 4))
            0: v = 32'(lim);
            1: v = 32'(-longint'(lim));
            2: v = 32'(lim + 1);
            3: v = 32'(-longint'(lim) - 1);
            default: v = 32'($urandom_range(0, 20)) - 32'd10;
          endcase
          send_word(btc_pkg::CmdEncode, v, w);
        end
        6, 7: send_word(btc_pkg::CmdDecode, $urandom, w);
        default: begin
          for (int i = 0; i < MaxTrits; i++) w[2*i +: 2] = 2'($urandom_range(0, 2));
          send_word(btc_pkg::CmdDecode, $urandom, w);
        end
      endcase
    end
  endtask

  initial begin
    logic [btc_pkg::CntW-1:0] settings[8];
    settings = '{5'd0, 5'd1, 5'd31, 5'd2, 5'd20, 5'd7, 5'd21, 5'd13};
    settings[7] = 5'($urandom_range(3, 19));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at the reset trit count
    send_word(btc_pkg::CmdEncode, 32'd0, '0);
    send_word(btc_pkg::CmdEncode, 32'd1, '1);
    send_word(btc_pkg::CmdEncode, -32'sd1, '0);
    send_word(btc_pkg::CmdEncode, 32'd2, '0);
    send_word(btc_pkg::CmdEncode, -32'sd2, '0);
    send_word(btc_pkg::CmdEncode, 32'd4, '0);
    send_word(btc_pkg::CmdEncode, 32'h7FFF_FFFF, '0);
    send_word(btc_pkg::CmdEncode, 32'h8000_0000, '0);
    send_word(btc_pkg::CmdEncode, 32'd1743392200, '0);
    send_word(btc_pkg::CmdEncode, 32'd1743392201, '0);
    send_word(btc_pkg::CmdEncode, -32'sd1743392200, '0);
    send_word(btc_pkg::CmdEncode, -32'sd1743392201, '0);
    send_word(btc_pkg::CmdEncode, 32'hFFFF_FFFF, '1);
    send_word(btc_pkg::CmdDecode, '1, '0);
    send_word(btc_pkg::CmdDecode, '0, '1);
    send_word(btc_pkg::CmdDecode, '0, 40'h55_5555_5555);
    send_word(btc_pkg::CmdDecode, '0, 40'hAA_AAAA_AAAA);
    send_word(btc_pkg::CmdDecode, '0, 40'h00_0000_0001);
    send_word(btc_pkg::CmdDecode, '0, 40'h00_0000_0002);
    send_word(btc_pkg::CmdDecode, '0, 40'h00_0000_0003);
    send_word(btc_pkg::CmdDecode, '0, 40'h80_0000_0000);

    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      write_trit_count(settings[ph]);
      calm = ($urandom_range(0, 3) == 0);
      if (ph < 3) begin
        send_word(btc_pkg::CmdDecode, '0, '1);
        send_word(btc_pkg::CmdDecode, '0, 40'h55_5555_5555);
        send_word(btc_pkg::CmdEncode, 32'h8000_0000, '0);
      end
      random_phase(58);
    end
    calm = 1'b0;

    drain_results();
    repeat (MaxTrits + 5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/btc_pkg.sv
src/btc_stage.sv
src/balanced_ternary_converter.sv
src/btc_checker.sv
tb/testbench.sv
